// File: rtl/core/bbwa_pkg.sv
package bbwa_pkg;

  // geometry and line store
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int ROW_W      = HEIGHT_W;
  localparam int PIX_W      = 8;
  localparam int LEVEL_W    = 8;
  localparam int GAIN_W     = 9;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(256);

  // window sum and averaging
  localparam int SUM_W    = PIX_W + 4;
  localparam int RECIP_SH = 15;
  localparam int RECIP9   = 3641;
  localparam int RECIP6   = 5462;
  localparam int MUL_W    = SUM_W + RECIP_SH;

  // attract arithmetic
  localparam int PROD_W   = 20;
  localparam int GAIN_SH  = 8;
  localparam int RES_W    = PROD_W - GAIN_SH;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_ATTRACT_MODE  = 3'd2,
    REG_ATTRACT_LEVEL = 3'd3,
    REG_ATTRACT_GAIN  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_BY4,
    DIV_BY6,
    DIV_BY9,
    DIV_SHR3
  } div_e;

  // one accepted beat on its way into the line store
  typedef struct packed {
    logic             emit;
    logic             col0;
    logic             top;
    logic             bot;
    logic             lft;
    logic             rgt;
    logic             last;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
  } item_t;

  // masked window sum on its way into the arithmetic
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    div_e             kind;
    logic             last;
  } sum_t;

endpackage

// File: rtl/core/bbwa_ctrl.sv
module bbwa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          clear_i,
  input  logic                          req_type_i,
  input  logic [bbwa_pkg::PIX_W-1:0]    pixel_in_i,
  input  logic [bbwa_pkg::WIDTH_W-1:0]  width_i,
  input  logic [bbwa_pkg::HEIGHT_W-1:0] height_i,
  output logic                          item_vld_o,
  output bbwa_pkg::item_t               item_o
);

  logic [bbwa_pkg::COL_W-1:0]   in_col_q, in_col_d;
  logic [bbwa_pkg::ROW_W-1:0]   in_row_q, in_row_d;
  logic [bbwa_pkg::COL_W-1:0]   out_col_q, out_col_d;
  logic [bbwa_pkg::ROW_W-1:0]   out_row_q, out_row_d;
  logic [bbwa_pkg::WIDTH_W-1:0] pend_q, pend_d;

  logic                         at_start, is_pix, is_drain, restart, emit;
  logic [bbwa_pkg::WIDTH_W-1:0] w_plus1, pend_eff, oc_inc, ic_inc;
  logic [bbwa_pkg::COL_W-1:0]   oc, drain_col;
  logic [bbwa_pkg::ROW_W-1:0]   orow;
  logic [bbwa_pkg::ROW_W:0]     or_inc, ir_inc;
  logic                         top, bot, rgt;

  // classify the beat against the stream position
  always_comb begin
    at_start  = (in_row_q == '0) && (in_col_q == '0);
    w_plus1   = width_i + bbwa_pkg::WIDTH_W'(1);
    is_pix    = accept_i && !req_type_i;
    is_drain  = accept_i && req_type_i && at_start && (pend_q != '0);
    restart   = is_pix && at_start && (pend_q != '0) && (pend_q < w_plus1);
    pend_eff  = restart ? '0 : pend_q;
    emit      = is_pix ? (pend_eff == w_plus1) : is_drain;
    oc        = restart ? '0 : out_col_q;
    orow      = restart ? '0 : out_row_q;
    oc_inc    = bbwa_pkg::WIDTH_W'(oc) + bbwa_pkg::WIDTH_W'(1);
    drain_col = (oc_inc >= width_i) ? '0 : oc_inc[bbwa_pkg::COL_W-1:0];
    top       = (orow == '0);
    bot       = (orow == height_i - bbwa_pkg::HEIGHT_W'(1));
    rgt       = (bbwa_pkg::WIDTH_W'(oc) == width_i - bbwa_pkg::WIDTH_W'(1));
  end

  // build the beat for the line store
  always_comb begin
    item_vld_o  = is_pix || is_drain;
    item_o.emit = emit;
    item_o.col  = req_type_i ? drain_col : in_col_q;
    item_o.col0 = (item_o.col == '0);
    item_o.top  = top;
    item_o.bot  = bot;
    item_o.lft  = (oc == '0);
    item_o.rgt  = rgt;
    item_o.last = bot && rgt;
    item_o.pix  = req_type_i ? '0 : pixel_in_i;
  end

  // advance input position, output position and the pending count
  always_comb begin
    ic_inc   = bbwa_pkg::WIDTH_W'(in_col_q) + bbwa_pkg::WIDTH_W'(1);
    ir_inc   = {1'b0, in_row_q} + 1'b1;
    or_inc   = {1'b0, orow} + 1'b1;
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (is_pix) begin
      if (ic_inc >= width_i) begin
        in_col_d = '0;
        in_row_d = (ir_inc >= {1'b0, height_i}) ? '0 : ir_inc[bbwa_pkg::ROW_W-1:0];
      end else begin
        in_col_d = ic_inc[bbwa_pkg::COL_W-1:0];
      end
    end
    out_col_d = oc;
    out_row_d = orow;
    if (emit) begin
      if (oc_inc >= width_i) begin
        out_col_d = '0;
        out_row_d = (or_inc >= {1'b0, height_i}) ? '0 : or_inc[bbwa_pkg::ROW_W-1:0];
      end else begin
        out_col_d = oc_inc[bbwa_pkg::COL_W-1:0];
      end
    end
    pend_d = pend_q;
    if (is_pix) begin
      pend_d = emit ? pend_eff : pend_eff + bbwa_pkg::WIDTH_W'(1);
    end else if (is_drain) begin
      pend_d = pend_q - bbwa_pkg::WIDTH_W'(1);
    end
    if (clear_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pend_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
    end
  end

  // the tail never holds more than one row plus one pixel
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= w_plus1)
    else $error("pending count above one row plus one pixel");

  // both columns stay inside the row
  a_cols_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bbwa_pkg::WIDTH_W'(in_col_q) < width_i) && (bbwa_pkg::WIDTH_W'(out_col_q) < width_i))
    else $error("column position outside the row");

  // a drain always comes out as a result
  a_drain_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_drain |-> (emit && item_vld_o && (pend_q != '0)))
    else $error("drain accepted without a result");

endmodule

// File: rtl/core/bbwa_window.sv
module bbwa_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            item_vld_i,
  input  bbwa_pkg::item_t item_i,
  input  logic            attract_i,
  output logic            sum_vld_o,
  output bbwa_pkg::sum_t  sum_o
);

  localparam int ENTRY_W = 2 * bbwa_pkg::PIX_W;

  // line store: upper row in the high byte, lower row in the low byte
  logic [ENTRY_W-1:0]         line_mem_q [bbwa_pkg::MAX_WIDTH];
  logic [ENTRY_W-1:0]         rd_q;
  logic [ENTRY_W-1:0]         fwd_data_q;
  logic                       fwd_hit_q;
  logic                       s1_vld_q;
  bbwa_pkg::item_t            s1_q;
  logic [bbwa_pkg::PIX_W-1:0] win_q [3][3];
  logic [bbwa_pkg::PIX_W-1:0] win_d [3][3];
  logic [bbwa_pkg::PIX_W-1:0] view  [3][3];
  logic                       sum_vld_q;
  bbwa_pkg::sum_t             sum_q, sum_d;

  logic [ENTRY_W-1:0]         rd, wdata;
  logic                       full, keep;

  // take the entry, or the value written to it at the edge that read it
  always_comb begin
    rd    = fwd_hit_q ? fwd_data_q : rd_q;
    wdata = {rd[bbwa_pkg::PIX_W-1:0], s1_q.pix};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q       <= line_mem_q[item_i.col];
      fwd_data_q <= wdata;
    end
    if (en_i && s1_vld_q) begin
      line_mem_q[s1_q.col] <= wdata;
    end
  end

  // shift the window, then select the cells around the output pixel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k][0] = win_q[k][1];
      win_d[k][1] = win_q[k][2];
    end
    win_d[0][2] = rd[ENTRY_W-1:bbwa_pkg::PIX_W];
    win_d[1][2] = rd[bbwa_pkg::PIX_W-1:0];
    win_d[2][2] = s1_q.pix;
    for (int r = 0; r < 3; r++) begin
      if (s1_q.col0) begin
        view[r][0] = win_q[r][1];
        view[r][1] = win_q[r][2];
        view[r][2] = '0;
      end else begin
        view[r][0] = win_d[r][0];
        view[r][1] = win_d[r][1];
        view[r][2] = win_d[r][2];
      end
    end
  end

  // masked sum and divisor choice
  always_comb begin
    full       = !s1_q.top && !s1_q.bot && !s1_q.lft && !s1_q.rgt;
    keep       = 1'b0;
    sum_d.sum  = '0;
    sum_d.last = s1_q.last;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        keep = !((r == 0) && s1_q.top) && !((r == 2) && s1_q.bot) &&
               !((j == 0) && s1_q.lft) && !((j == 2) && (s1_q.rgt || s1_q.col0)) &&
               !((r == 1) && (j == 1) && attract_i && full);
        if (keep) begin
          sum_d.sum = sum_d.sum + bbwa_pkg::SUM_W'(view[r][j]);
        end
      end
    end
    if (attract_i && full) begin
      sum_d.kind = bbwa_pkg::DIV_SHR3;
    end else if (full) begin
      sum_d.kind = bbwa_pkg::DIV_BY9;
    end else if ((s1_q.top || s1_q.bot) && (s1_q.lft || s1_q.rgt)) begin
      sum_d.kind = bbwa_pkg::DIV_BY4;
    end else begin
      sum_d.kind = bbwa_pkg::DIV_BY6;
    end
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
      sum_vld_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[r][j] <= '0;
        end
      end
    end else if (en_i) begin
      s1_vld_q  <= item_vld_i;
      fwd_hit_q <= s1_vld_q && (s1_q.col == item_i.col);
      sum_vld_q <= s1_vld_q && s1_q.emit;
      if (s1_vld_q) begin
        win_q <= win_d;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= item_i;
      sum_q <= sum_d;
    end
  end

  assign sum_vld_o = sum_vld_q;
  assign sum_o     = sum_q;

  // an access to the entry that the previous beat writes is always forwarded
  a_fwd_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && s1_vld_q && item_vld_i && (s1_q.col == item_i.col)) |=> fwd_hit_q)
    else $error("same-entry access without forwarding");

  // a result leaves stage one only from a beat that asked for one
  a_sum_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sum_vld_q) |-> $past(s1_vld_q && s1_q.emit))
    else $error("window sum without an emitting beat");

endmodule

// File: rtl/core/bbwa_post.sv
module bbwa_post (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         sum_vld_i,
  input  bbwa_pkg::sum_t               sum_i,
  input  logic                         attract_i,
  input  logic [bbwa_pkg::LEVEL_W-1:0] level_i,
  input  logic [bbwa_pkg::GAIN_W-1:0]  gain_i,
  output logic                         out_vld_o,
  output logic [bbwa_pkg::PIX_W-1:0]   pixel_o,
  output logic                         last_o
);

  logic                              s3_vld_q, s4_vld_q, out_vld_q;
  logic [bbwa_pkg::PIX_W-1:0]        avg_q, avg_d, avg4_q, pix_q, pix_d;
  logic                              s3_last_q, s4_last_q, last_q;
  logic signed [bbwa_pkg::PROD_W-1:0] prod_q, prod_d, diff_s, gain_s, adj;
  logic signed [bbwa_pkg::RES_W-1:0]  quo, res;
  logic [bbwa_pkg::MUL_W-1:0]        m9, m6;
  logic [bbwa_pkg::PIX_W-1:0]        sat;

  // divide the window sum by its cell count
  always_comb begin
    m9 = bbwa_pkg::MUL_W'(sum_i.sum) * bbwa_pkg::MUL_W'(bbwa_pkg::RECIP9);
    m6 = bbwa_pkg::MUL_W'(sum_i.sum) * bbwa_pkg::MUL_W'(bbwa_pkg::RECIP6);
    case (sum_i.kind)
      bbwa_pkg::DIV_BY4:  avg_d = sum_i.sum[2 +: bbwa_pkg::PIX_W];
      bbwa_pkg::DIV_SHR3: avg_d = sum_i.sum[3 +: bbwa_pkg::PIX_W];
      bbwa_pkg::DIV_BY9:  avg_d = m9[bbwa_pkg::RECIP_SH +: bbwa_pkg::PIX_W];
      bbwa_pkg::DIV_BY6:  avg_d = m6[bbwa_pkg::RECIP_SH +: bbwa_pkg::PIX_W];
      default:            avg_d = '0;
    endcase
  end

  // scale the distance from the level
  always_comb begin
    diff_s = $signed({{(bbwa_pkg::PROD_W-bbwa_pkg::PIX_W){1'b0}}, avg_q}) -
             $signed({{(bbwa_pkg::PROD_W-bbwa_pkg::LEVEL_W){1'b0}}, level_i});
    gain_s = $signed({{(bbwa_pkg::PROD_W-bbwa_pkg::GAIN_W){1'b0}}, gain_i});
    prod_d = diff_s * gain_s;
  end

  // truncate toward zero, add the level back, clamp to a pixel
  always_comb begin
    adj = prod_q[bbwa_pkg::PROD_W-1] ?
          prod_q + bbwa_pkg::PROD_W'((1 << bbwa_pkg::GAIN_SH) - 1) : prod_q;
    quo = adj[bbwa_pkg::PROD_W-1:bbwa_pkg::GAIN_SH];
    res = quo + $signed({{(bbwa_pkg::RES_W-bbwa_pkg::LEVEL_W){1'b0}}, level_i});
    if (res[bbwa_pkg::RES_W-1]) begin
      sat = '0;
    end else if (|res[bbwa_pkg::RES_W-2:bbwa_pkg::PIX_W]) begin
      sat = '1;
    end else begin
      sat = res[bbwa_pkg::PIX_W-1:0];
    end
    pix_d = attract_i ? sat : avg4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q  <= sum_vld_i;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      avg_q     <= avg_d;
      s3_last_q <= sum_i.last;
      avg4_q    <= avg_q;
      prod_q    <= prod_d;
      s4_last_q <= s3_last_q;
      pix_q     <= pix_d;
      last_q    <= s4_last_q;
    end
  end

  assign out_vld_o = out_vld_q;
  assign pixel_o   = pix_q;
  assign last_o    = last_q;

  // every beat in stage four reaches the output register
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && s4_vld_q) |=> out_vld_q)
    else $error("result dropped in the arithmetic pipe");

endmodule

// File: rtl/core/box_blur_with_attract.sv
// Streaming 3x3 box blur with optional pull toward a level. Pixels enter in raster
// order, one beat per clock sustained while the output is not stalled, and the
// blurred frame leaves in raster order one row plus one pixel behind; drain beats
// push out the tail after the last pixel of a frame. The rate is set by the line
// store, one 1024 x 16 RAM that is read for every beat and written back by that
// beat from stage one, with a forward for back-to-back use of the same column. A
// result passes from stage one through the window sum, average and attract product
// into the output register. Stall on a valid output holds the whole pipeline and
// raises stall on the input. The line store needs no clearing after reset. Write
// the configuration only while idle; a width or height write restarts the stream.
module box_blur_with_attract (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [bbwa_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bbwa_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            frame_last_o,
  input  logic                            cfg_we_i,
  input  logic [bbwa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbwa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [bbwa_pkg::WIDTH_W-1:0]  frame_width_q;
  logic [bbwa_pkg::HEIGHT_W-1:0] frame_height_q;
  logic                          attract_mode_q;
  logic [bbwa_pkg::LEVEL_W-1:0]  attract_level_q;
  logic [bbwa_pkg::GAIN_W-1:0]   attract_gain_q;

  logic [bbwa_pkg::WIDTH_W-1:0]  w_eff;
  logic [bbwa_pkg::HEIGHT_W-1:0] h_eff;
  logic                          en, accept, clear;
  logic                          item_vld, sum_vld;
  bbwa_pkg::item_t               item;
  bbwa_pkg::sum_t                sum;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= bbwa_pkg::WIDTH_RESET;
      frame_height_q  <= bbwa_pkg::HEIGHT_RESET;
      attract_mode_q  <= 1'b0;
      attract_level_q <= '0;
      attract_gain_q  <= bbwa_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbwa_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[bbwa_pkg::WIDTH_W-1:0];
        bbwa_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[bbwa_pkg::HEIGHT_W-1:0];
        bbwa_pkg::REG_ATTRACT_MODE:  attract_mode_q  <= cfg_data_i[0];
        bbwa_pkg::REG_ATTRACT_LEVEL: attract_level_q <= cfg_data_i[bbwa_pkg::LEVEL_W-1:0];
        bbwa_pkg::REG_ATTRACT_GAIN:  attract_gain_q  <= cfg_data_i[bbwa_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the geometry
  always_comb begin
    if (frame_width_q < bbwa_pkg::WIDTH_W'(2)) begin
      w_eff = bbwa_pkg::WIDTH_W'(2);
    end else if (frame_width_q > bbwa_pkg::WIDTH_W'(bbwa_pkg::MAX_WIDTH)) begin
      w_eff = bbwa_pkg::WIDTH_W'(bbwa_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width_q;
    end
    h_eff = (frame_height_q < bbwa_pkg::HEIGHT_W'(2)) ? bbwa_pkg::HEIGHT_W'(2) : frame_height_q;
  end

  // advance the pipe unless a finished result is held
  always_comb begin
    en         = !(out_valid_o && out_stall_i);
    in_stall_o = !en;
    accept     = in_valid_i && en;
    clear      = cfg_we_i && ((cfg_idx_i == bbwa_pkg::REG_FRAME_WIDTH) ||
                              (cfg_idx_i == bbwa_pkg::REG_FRAME_HEIGHT));
  end

  bbwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .clear_i    (clear),
    .req_type_i (req_type_i),
    .pixel_in_i (pixel_in_i),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  bbwa_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .item_vld_i (item_vld),
    .item_i     (item),
    .attract_i  (attract_mode_q),
    .sum_vld_o  (sum_vld),
    .sum_o      (sum)
  );

  bbwa_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .sum_vld_i (sum_vld),
    .sum_i     (sum),
    .attract_i (attract_mode_q),
    .level_i   (attract_level_q),
    .gain_i    (attract_gain_q),
    .out_vld_o (out_valid_o),
    .pixel_o   (pixel_out_o),
    .last_o    (frame_last_o)
  );

endmodule
